>>> src/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the range fault detector with hysteresis.
// ----------------------------------------------------------------------------
package rfd_pkg;

  // Default widths of the sample path and of the run counters.
  localparam int unsigned SAMPLE_WIDTH_DEFAULT = 32;
  localparam int unsigned RUN_WIDTH_DEFAULT    = 16;

  // Fixed widths of the timestamp and of the fault total.
  localparam int unsigned TIME_WIDTH  = 32;
  localparam int unsigned FAULT_WIDTH = 32;

  // Reset value of both run limits.
  localparam int unsigned RUN_LIMIT_RESET = 3;

  // Leaving recovering takes twice the good run limit, so the limit is
  // shifted left by this amount.
  localparam int unsigned GOOD_FACTOR_SHIFT = 1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  localparam cfg_index_t REG_LOWER_BOUND    = 2'd0;
  localparam cfg_index_t REG_UPPER_BOUND    = 2'd1;
  localparam cfg_index_t REG_BAD_RUN_LIMIT  = 2'd2;
  localparam cfg_index_t REG_GOOD_RUN_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    MODE_NOMINAL    = 2'd0,
    MODE_ANOMALY    = 2'd1,
    MODE_RECOVERING = 2'd2
  } mode_t;

  // Transition report of one frame, from the tracker to the result stage.
  typedef struct packed {
    logic  changed;
    mode_t from_mode;
    mode_t to_mode;
  } mode_report_t;

endpackage

>>> src/rfd_frame_if.sv
// ----------------------------------------------------------------------------
// rfd_frame_if
// Valid/ready channel for telemetry frames.
// ----------------------------------------------------------------------------
interface rfd_frame_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           hw_ok;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [31:0]                    time_ms;

  modport source (output valid, output hw_ok, output sample, output time_ms,
                  input ready);
  modport sink (input valid, input hw_ok, input sample, input time_ms,
                output ready);
endinterface

>>> src/rfd_result_if.sv
// ----------------------------------------------------------------------------
// rfd_result_if
// Valid/ready channel that carries one detector result per transaction.
// ----------------------------------------------------------------------------
interface rfd_result_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           changed;
  logic [1:0]                     from_mode;
  logic [1:0]                     to_mode;
  logic [31:0]                    event_time;
  logic signed [SAMPLE_WIDTH-1:0] event_sample;
  logic [31:0]                    fault_total;

  modport source (output valid, output changed, output from_mode, output to_mode,
                  output event_time, output event_sample, output fault_total,
                  input ready);
  modport sink (input valid, input changed, input from_mode, input to_mode,
                input event_time, input event_sample, input fault_total,
                output ready);
endinterface

>>> src/rfd_tracker.sv
// ----------------------------------------------------------------------------
// rfd_tracker
// Range check and three-state hysteresis machine with its run counters and
// the wrapping fault counter. State moves on each advancing frame.
// ----------------------------------------------------------------------------
module rfd_tracker
  import rfd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
  parameter int unsigned RUN_WIDTH    = RUN_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           hw_ok,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] lower_bound,
  input  logic signed [SAMPLE_WIDTH-1:0] upper_bound,
  input  logic [RUN_WIDTH-1:0]           bad_run_limit,
  input  logic [RUN_WIDTH-1:0]           good_run_limit,
  output mode_report_t                   report,
  output logic [FAULT_WIDTH-1:0]         fault_total_next
);

  mode_t                  mode;
  mode_t                  mode_next;
  logic [RUN_WIDTH-1:0]   bad_run;
  logic [RUN_WIDTH-1:0]   bad_run_next;
  logic [RUN_WIDTH:0]     good_run;
  logic [RUN_WIDTH:0]     good_run_next;
  logic [FAULT_WIDTH-1:0] fault_counter;

  logic                   good;
  logic [RUN_WIDTH-1:0]   bad_inc;
  logic [RUN_WIDTH:0]     good_inc;
  logic [RUN_WIDTH:0]     good_needed;

  assign good = hw_ok && (sample >= lower_bound) && (sample <= upper_bound);

  // Run counters saturate rather than wrap.
  assign bad_inc  = (&bad_run) ? bad_run : bad_run + 1'b1;
  assign good_inc = (&good_run) ? good_run : good_run + 1'b1;
  assign good_needed = {1'b0, good_run_limit} << GOOD_FACTOR_SHIFT;

  always_comb begin
    mode_next     = mode;
    bad_run_next  = bad_run;
    good_run_next = good_run;
    unique case (mode)
      MODE_ANOMALY: begin
        if (good) begin
          mode_next = MODE_RECOVERING;
        end else begin
          good_run_next = '0;
        end
      end
      MODE_RECOVERING: begin
        if (good) begin
          good_run_next = good_inc;
          if (good_inc >= good_needed) begin
            mode_next = MODE_NOMINAL;
          end
        end else begin
          mode_next = MODE_ANOMALY;
        end
      end
      default: begin
        if (!good) begin
          bad_run_next  = bad_inc;
          good_run_next = '0;
          if (bad_inc >= bad_run_limit) begin
            mode_next = MODE_ANOMALY;
          end
        end else begin
          bad_run_next = '0;
        end
      end
    endcase
    // Every transition starts both runs over.
    if (mode_next != mode) begin
      bad_run_next  = '0;
      good_run_next = '0;
    end
  end

  assign report.changed   = (mode_next != mode);
  assign report.from_mode = mode;
  assign report.to_mode   = mode_next;
  assign fault_total_next = (report.changed && (mode_next == MODE_ANOMALY))
                            ? fault_counter + 1'b1 : fault_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NOMINAL;
      bad_run       <= '0;
      good_run      <= '0;
      fault_counter <= '0;
    end else if (advance) begin
      mode          <= mode_next;
      bad_run       <= bad_run_next;
      good_run      <= good_run_next;
      fault_counter <= fault_total_next;
    end
  end

endmodule

>>> src/range_fault_detector_with_hysteresis.sv
// ----------------------------------------------------------------------------
// range_fault_detector_with_hysteresis
// Range check of telemetry frames with a nominal/anomaly/recovering machine.
// ----------------------------------------------------------------------------
// Each accepted frame yields exactly one result transaction, in order. The
// block takes one frame per clock cycle when the result side keeps up; a
// frame passes from the input register into the result register once the
// result register is free, and while it waits in the input register the range
// check and the state update run into the result register. The combinational
// update of the mode, run counters and fault counter sets that rate.
// Configuration writes take effect at the next clock edge; the user must make
// them while no frame is in flight, as the block itself does not enforce it.
module range_fault_detector_with_hysteresis
  import rfd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
  parameter int unsigned RUN_WIDTH    = RUN_WIDTH_DEFAULT,
  localparam int unsigned CFG_WIDTH   = (SAMPLE_WIDTH > RUN_WIDTH) ? SAMPLE_WIDTH
                                                                 : RUN_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  rfd_frame_if.sink            frame,
  rfd_result_if.source         report
);

  // Configuration registers.
  logic signed [SAMPLE_WIDTH-1:0] lower_bound;
  logic signed [SAMPLE_WIDTH-1:0] upper_bound;
  logic [RUN_WIDTH-1:0]           bad_run_limit;
  logic [RUN_WIDTH-1:0]           good_run_limit;

  // Input register.
  logic                           in_valid;
  logic                           in_hw_ok;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic [TIME_WIDTH-1:0]          in_time;

  // Result register.
  logic                           res_valid;
  mode_report_t                   res_report;
  logic [TIME_WIDTH-1:0]          res_time;
  logic signed [SAMPLE_WIDTH-1:0] res_sample;
  logic [FAULT_WIDTH-1:0]         res_fault;

  logic                           res_free;
  logic                           advance;
  logic                           accept;
  mode_report_t                   step_report;
  logic [FAULT_WIDTH-1:0]         step_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound    <= '0;
      upper_bound    <= '0;
      bad_run_limit  <= RUN_WIDTH'(RUN_LIMIT_RESET);
      good_run_limit <= RUN_WIDTH'(RUN_LIMIT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWER_BOUND:    lower_bound    <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_UPPER_BOUND:    upper_bound    <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_BAD_RUN_LIMIT:  bad_run_limit  <= cfg_data[RUN_WIDTH-1:0];
        REG_GOOD_RUN_LIMIT: good_run_limit <= cfg_data[RUN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The result register frees up when empty or when its transaction
  // completes, so the pipeline keeps moving while a result is taken.
  assign res_free    = !res_valid || report.ready;
  assign advance     = in_valid && res_free;
  assign frame.ready = !in_valid || advance;
  assign accept      = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_hw_ok  <= frame.hw_ok;
      in_sample <= frame.sample;
      in_time   <= frame.time_ms;
    end
  end

  rfd_tracker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .RUN_WIDTH    (RUN_WIDTH)
  ) u_tracker (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .hw_ok            (in_hw_ok),
    .sample           (in_sample),
    .lower_bound      (lower_bound),
    .upper_bound      (upper_bound),
    .bad_run_limit    (bad_run_limit),
    .good_run_limit   (good_run_limit),
    .report           (step_report),
    .fault_total_next (step_fault)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_report <= step_report;
      res_time   <= in_time;
      res_sample <= in_sample;
      res_fault  <= step_fault;
    end
  end

  assign report.valid        = res_valid;
  assign report.changed      = res_report.changed;
  assign report.from_mode    = res_report.from_mode;
  assign report.to_mode      = res_report.to_mode;
  assign report.event_time   = res_time;
  assign report.event_sample = res_sample;
  assign report.fault_total  = res_fault;

`ifndef SYNTHESIS
  // An empty result register never leaves the input side blocked.
  assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> frame.ready)
    else $error("frame side stalled with an empty result register");

  // A delivered result flags a transition exactly when its modes differ.
  assert property (@(posedge clk) disable iff (rst)
    report.valid |-> (report.changed == (report.from_mode != report.to_mode)))
    else $error("transition flag disagrees with reported modes");

  // The fault total steps by one exactly on a transaction entering anomaly.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (res_fault == ($past(step_report.changed)
                               && ($past(step_report.to_mode) == MODE_ANOMALY)
                               ? $past(u_tracker.fault_counter) + 1'b1
                               : $past(u_tracker.fault_counter))))
    else $error("fault total did not follow the entry into anomaly");
`endif

endmodule
